// File: hdl/dpr_pkg.sv
// dpr_pkg: shared types and constants for the decimated PI regulator.
// No dependencies; imported by dpr_update and decimated_pi_regulator_unit.
package dpr_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM_FACTOR = 2'd2;

  localparam logic [15:0] FACTOR_RESET = 16'd64;

  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 120;

  // one regulator update, as computed from the current item and state
  typedef struct packed {
    logic signed [16:0] tracking_error;
    logic signed [23:0] proportional_term;
    logic [23:0] integral_term;
    logic signed [17:0] drive;
  } update_t;

endpackage

// File: hdl/dpr_update.sv
// dpr_update: combinational PI update (error, P term, clamped integrator, drive).
// Depends on dpr_pkg for update_t.
module dpr_update import dpr_pkg::*; (
  input  logic [15:0] target_level,
  input  logic [15:0] max_duty,
  input  logic [15:0] feedback,
  input  logic [23:0] integrator,
  output update_t upd
);

  logic signed [16:0] err;
  logic signed [23:0] prop;
  logic signed [25:0] err_ki;
  logic signed [25:0] acc;
  logic signed [25:0] acc_max;
  logic signed [25:0] acc_clamped;
  logic signed [25:0] sum;

  always_comb begin
    err = $signed({1'b0, target_level}) - $signed({1'b0, feedback});
    prop = $signed({{7{err[16]}}, err}) * 24'sd100;
    err_ki = $signed({{9{err[16]}}, err}) * 26'sd10;
    acc = $signed({2'b00, integrator}) + err_ki;
    acc_max = $signed({2'b00, max_duty, 8'h00});
    if (acc > acc_max) begin
      acc_clamped = acc_max;
    end else if (acc < 26'sd0) begin
      acc_clamped = 26'sd0;
    end else begin
      acc_clamped = acc;
    end
    sum = $signed({{2{prop[23]}}, prop}) + acc_clamped;

    upd.tracking_error = err;
    upd.proportional_term = prop;
    upd.integral_term = acc_clamped[23:0];
    // floor shift by eight: just drop the low byte of the signed sum
    upd.drive = sum[25:8];
  end

endmodule

// File: hdl/decimated_pi_regulator_unit.sv
// Decimated PI regulator: input register, combinational update, result register.
// The result register loads when the tick held in the input register is consumed.
// Throughput: one tick per cycle; a tick that yields a result waits only while the
// result register is held by the sink.
// Reset (rst, synchronous): clears phase, integrator, update count and registers
// to their defaults (decimation factor 64). Depends on dpr_pkg and dpr_update.
module decimated_pi_regulator_unit import dpr_pkg::*; (
  input  logic clk,
  input  logic rst,

  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [0] run, [16:1] feedback, [23:17] zero
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,

  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [16:0] tracking_error, [40:17] proportional_term, [64:41] integral_term,
  // [82:65] drive, [114:83] update_count, [119:115] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [15:0] target_level;
  logic [15:0] max_duty;
  logic [15:0] ticks_per_update;

  logic s1_valid;
  logic s1_run;
  logic [15:0] s1_feedback;

  logic [15:0] phase;
  logic [23:0] integrator;
  logic [31:0] updates_done;
  logic [31:0] updates_done_next;

  update_t upd;
  update_t out_upd;
  logic [31:0] out_count;

  logic [15:0] factor;
  logic [16:0] phase_inc;
  logic wrap;
  logic produce;
  logic out_free;
  logic consume;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= '0;
      max_duty <= '0;
      ticks_per_update <= FACTOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET_LEVEL: target_level <= cfg_data;
        REG_MAX_DUTY:     max_duty <= cfg_data;
        REG_DECIM_FACTOR: ticks_per_update <= cfg_data;
        default: ;
      endcase
    end
  end

  dpr_update u_update (
    .target_level(target_level),
    .max_duty(max_duty),
    .feedback(s1_feedback),
    .integrator(integrator),
    .upd(upd)
  );

  always_comb begin
    factor = (ticks_per_update == 16'd0) ? 16'd1 : ticks_per_update;
    phase_inc = {1'b0, phase} + 17'd1;
    wrap = (phase_inc >= {1'b0, factor});
    produce = wrap && s1_run;
    out_free = !m_axis_tvalid || m_axis_tready;
    // a tick with no result never waits on the sink
    consume = s1_valid && (!produce || out_free);
    updates_done_next = updates_done + 32'd1;
  end

  assign s_axis_tready = !s1_valid || consume;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_run <= s_axis_tdata[0];
      s1_feedback <= s_axis_tdata[16:1];
    end
  end

  // regulator state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      integrator <= '0;
      updates_done <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (consume) begin
        phase <= wrap ? 16'd0 : phase_inc[15:0];
      end
      if (consume && produce) begin
        integrator <= upd.integral_term;
        updates_done <= updates_done_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (consume && produce) begin
      out_upd <= upd;
      out_count <= updates_done_next;
    end
  end

  assign m_axis_tdata = {5'b00000, out_count, out_upd.drive, out_upd.integral_term,
                         out_upd.proportional_term, out_upd.tracking_error};

`ifndef NO_ASSERTIONS
  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_upd.integral_term <= {max_duty, 8'h00}))
    else $error("integral term above clamp");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_count == updates_done))
    else $error("result count out of step with update counter");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && produce && !out_free))
    else $error("input stalled without a blocked result");

  a_wrap_counts: assert property (@(posedge clk) disable iff (rst)
    (consume && produce) |=> (updates_done == $past(updates_done) + 32'd1))
    else $error("update counter did not advance");
`endif

endmodule
